### rtl/fvws_pkg.sv
// Package: shared types, codes and default sizes for the wavetable sequencer.
`default_nettype none
package fvws_pkg;

    // Default sizes
    localparam int VOICES_DEF         = 4;
    localparam int WAVE_DEPTH_DEF     = 64;
    localparam int ENVELOPE_DEPTH_DEF = 128;
    localparam int PITCH_DEPTH_DEF    = 128;
    localparam int SONG_DEPTH_DEF     = 1024;

    // Register reset values and fixed constants
    localparam logic [7:0]  DIVIDER_RESET   = 8'd92;
    localparam logic [12:0] END_PAUSE_RESET = 13'd500;
    localparam logic [7:0]  NOTE_OFFSET     = 8'd9;
    localparam int          VOICE_SEL_W     = 3;

    // Configuration register indexes
    localparam logic REG_TICK_DIVIDER = 1'b0;
    localparam logic REG_END_PAUSE    = 1'b1;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_WAVE  = 3'd1,
        CMD_ENV   = 3'd2,
        CMD_PITCH = 3'd3,
        CMD_SONG  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_APPLY  = 2'd2
    } t_seq_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  address;
        logic [23:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_out_item;

    // Retrigger of one voice from the sequencer
    typedef struct packed {
        logic                   en;
        logic [VOICE_SEL_W-1:0] voice;
        logic [15:0]            incr;
    } t_voice_load;

endpackage
`default_nettype wire

### rtl/fvws_voices.sv
// Voice bank: phase and envelope counters with per-voice wave and envelope memories.
`default_nettype none
module fvws_voices #(
    parameter int VOICES         = fvws_pkg::VOICES_DEF,
    parameter int WAVE_DEPTH     = fvws_pkg::WAVE_DEPTH_DEF,
    parameter int ENVELOPE_DEPTH = fvws_pkg::ENVELOPE_DEPTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_tick,
    input  wire                        i_wave_we,
    input  wire                        i_env_we,
    input  wire  [9:0]                 i_addr,
    input  wire  [7:0]                 i_data,
    input  fvws_pkg::t_voice_load      i_load,
    output logic [7:0]                 o_wave [VOICES],
    output logic [7:0]                 o_env  [VOICES]
);
    import fvws_pkg::*;

    localparam int WAW = $clog2(WAVE_DEPTH);
    localparam int EAW = $clog2(ENVELOPE_DEPTH);

    logic [15:0]  r_phase  [VOICES];
    logic [15:0]  r_incr   [VOICES];
    logic [15:0]  r_envpos [VOICES];
    logic [7:0]   r_wave_mem [VOICES][WAVE_DEPTH];
    logic [7:0]   r_env_mem  [VOICES][ENVELOPE_DEPTH];
    logic [7:0]   r_wave_q [VOICES];
    logic [7:0]   r_env_q  [VOICES];
    logic         r_env_on [VOICES];

    logic [15:0]  n_phase  [VOICES];
    logic         env_on   [VOICES];
    logic [WAW-1:0] wave_idx [VOICES];
    logic [EAW-1:0] env_idx  [VOICES];

    // Next phase and table indexes per voice
    always_comb begin
        for (int v = 0; v < VOICES; v++) begin
            n_phase[v]  = r_phase[v] + r_incr[v];
            wave_idx[v] = WAW'(n_phase[v][15:10]);
            env_on[v]   = {1'b0, r_envpos[v][15:8]} < 9'(ENVELOPE_DEPTH);
            env_idx[v]  = EAW'(r_envpos[v][15:8]);
        end
    end

    // Advance counters on a tick, retrigger on a sequencer load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v]  <= '0;
                r_incr[v]   <= '0;
                r_envpos[v] <= '0;
            end
        end else begin
            for (int v = 0; v < VOICES; v++) begin
                if (i_load.en && i_load.voice == VOICE_SEL_W'(v)) begin
                    r_incr[v]   <= i_load.incr;
                    r_phase[v]  <= '0;
                    r_envpos[v] <= '0;
                end else if (i_tick) begin
                    r_phase[v] <= n_phase[v];
                    if (env_on[v]) begin
                        r_envpos[v] <= r_envpos[v] + 16'd1;
                    end
                end
            end
        end
    end

    // Table memories: one copy per voice, one read port each
    always_ff @(posedge i_clk) begin
        for (int v = 0; v < VOICES; v++) begin
            if (i_wave_we) begin
                r_wave_mem[v][WAW'(i_addr)] <= i_data;
            end
            if (i_env_we) begin
                r_env_mem[v][EAW'(i_addr)] <= i_data;
            end
            if (i_tick) begin
                r_wave_q[v] <= r_wave_mem[v][wave_idx[v]];
                r_env_q[v]  <= r_env_mem[v][env_idx[v]];
                r_env_on[v] <= env_on[v];
            end
        end
    end

    // Drop the envelope once it has run past the table
    always_comb begin
        for (int v = 0; v < VOICES; v++) begin
            o_wave[v] = r_wave_q[v];
            o_env[v]  = r_env_on[v] ? r_env_q[v] : 8'd0;
        end
    end

endmodule
`default_nettype wire

### rtl/fvws_mixer.sv
// Mixer: scale each voice by its envelope, sum to two channels, register the sample.
`default_nettype none
module fvws_mixer #(
    parameter int VOICES = fvws_pkg::VOICES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_tick,
    input  wire  [7:0]           i_wave [VOICES],
    input  wire  [7:0]           i_env  [VOICES],
    output logic                 o_free,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output fvws_pkg::t_out_item  o_out_item
);
    import fvws_pkg::*;

    localparam int SUM_W = 9 + $clog2(VOICES);

    logic              r_s1_valid;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic              advance;
    logic [15:0]       prod [VOICES];
    logic [SUM_W-1:0]  sum_l;
    logic [SUM_W-1:0]  sum_r;
    logic [7:0]        left8;
    logic [7:0]        right8;

    // Move the fetched bytes on when the output register is free
    assign advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_free  = !r_s1_valid || advance;

    always_comb begin
        sum_l = '0;
        sum_r = '0;
        for (int v = 0; v < VOICES; v++) begin
            prod[v] = i_wave[v] * i_env[v];
            if (v < VOICES / 2) begin
                sum_l = sum_l + SUM_W'(prod[v][15:8]);
            end else begin
                sum_r = sum_r + SUM_W'(prod[v][15:8]);
            end
        end
        left8  = sum_l[8:1];
        right8 = sum_r[8:1];
    end

    // Hold control state for the fetch stage and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Center each 8-bit mix into signed PCM
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.left_sample  <= {left8 ^ 8'h80, 8'h00};
            r_out_item.right_sample <= {right8 ^ 8'h80, 8'h00};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

### rtl/fvws_sequencer.sv
// Sequencer: tick divider, delay counter, song and pitch memories, voice retrigger.
`default_nettype none
module fvws_sequencer #(
    parameter int VOICES      = fvws_pkg::VOICES_DEF,
    parameter int PITCH_DEPTH = fvws_pkg::PITCH_DEPTH_DEF,
    parameter int SONG_DEPTH  = fvws_pkg::SONG_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire                    i_cfg_index,
    input  wire  [12:0]            i_cfg_data,
    input  wire                    i_tick,
    input  wire                    i_pitch_we,
    input  wire                    i_song_we,
    input  wire  [9:0]             i_addr,
    input  wire  [23:0]            i_data,
    output logic                   o_busy,
    output fvws_pkg::t_voice_load  o_load
);
    import fvws_pkg::*;

    localparam int PAW = $clog2(PITCH_DEPTH);
    localparam int SAW = $clog2(SONG_DEPTH);

    t_seq_state             r_state, n_state;
    logic [7:0]             r_div;
    logic [12:0]            r_end_pause;
    logic [7:0]             r_cnt, n_cnt;
    logic [12:0]            r_delay, n_delay;
    logic [SAW-1:0]         r_pos, n_pos;
    logic [VOICE_SEL_W-1:0] r_voice, n_voice;
    logic [23:0]            r_song_mem [SONG_DEPTH];
    logic [15:0]            r_pitch_mem [PITCH_DEPTH];
    logic [23:0]            r_song_q;
    logic [15:0]            r_pitch_q;

    logic [8:0]             cnt_inc;
    logic [12:0]            dec_delay;
    logic [7:0]             note;
    logic [7:0]             note_off;
    logic [PAW-1:0]         pitch_idx;
    logic [3:0]             voice_raw;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= DIVIDER_RESET;
            r_end_pause <= END_PAUSE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TICK_DIVIDER: r_div       <= i_cfg_data[7:0];
                REG_END_PAUSE:    r_end_pause <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode song entry fields
    always_comb begin
        note      = r_song_q[7:0];
        voice_raw = {2'b00, r_song_q[9:8]};
        if (voice_raw >= 4'(VOICES)) begin
            voice_raw = voice_raw - 4'(VOICES);
        end
        note_off = (note < NOTE_OFFSET) ? 8'd0 : note - NOTE_OFFSET;
        if (note_off > 8'(PITCH_DEPTH - 1)) begin
            note_off = 8'(PITCH_DEPTH - 1);
        end
        pitch_idx = PAW'(note_off);
    end

    // Next state: divide ticks, count down, fetch and apply entries
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_delay   = r_delay;
        n_pos     = r_pos;
        n_voice   = r_voice;
        cnt_inc   = {1'b0, r_cnt} + 9'd1;
        dec_delay = (r_delay != 13'd0) ? r_delay - 13'd1 : 13'd0;
        o_load    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_tick) begin
                    if (cnt_inc >= {1'b0, r_div}) begin
                        n_cnt   = 8'd0;
                        n_delay = dec_delay;
                        if (dec_delay == 13'd0) begin
                            n_state = S_DECODE;
                        end
                    end else begin
                        n_cnt = cnt_inc[7:0];
                    end
                end
            end
            S_DECODE: begin
                n_pos   = r_pos + SAW'(1);
                n_delay = r_song_q[23:11];
                n_voice = voice_raw[VOICE_SEL_W-1:0];
                n_state = S_IDLE;
                if (note != 8'd0) begin
                    n_state = S_APPLY;
                end else if (r_song_q[23:11] == 13'd0) begin
                    n_delay = r_end_pause;
                    n_pos   = SAW'(1);
                end
            end
            S_APPLY: begin
                o_load.en    = 1'b1;
                o_load.voice = r_voice;
                o_load.incr  = r_pitch_q;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 8'd0;
            r_delay <= 13'd1;
            r_pos   <= '0;
            r_voice <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_delay <= n_delay;
            r_pos   <= n_pos;
            r_voice <= n_voice;
        end
    end

    // Song and pitch memories with registered reads
    always_ff @(posedge i_clk) begin
        if (i_song_we) begin
            r_song_mem[SAW'(i_addr)] <= i_data;
        end
        if (i_pitch_we) begin
            r_pitch_mem[PAW'(i_addr)] <= i_data[15:0];
        end
        if (r_state == S_IDLE) begin
            r_song_q <= r_song_mem[r_pos];
        end
        if (r_state == S_DECODE) begin
            r_pitch_q <= r_pitch_mem[pitch_idx];
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### rtl/four_voice_wavetable_sequencer_top.sv
// Top level of the four-voice wavetable synthesizer with song sequencer.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid, o_in_ready, i_in_item         | in
//  output   | o_out_valid, i_out_ready, o_out_item      | out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// A tick or table write is taken every cycle while o_in_ready is high; a tick's sample
// passes the fetch stage and output register. On reaching a song entry o_in_ready drops
// for one cycle (rest, end of song) or over decode, pitch read and retrigger (note).
// Output stalls back up through one fetch stage and the output register.
// Reset is synchronous; the table memories hold no reset and must be loaded first.
`default_nettype none
module four_voice_wavetable_sequencer_top #(
    parameter int VOICES         = fvws_pkg::VOICES_DEF,
    parameter int WAVE_DEPTH     = fvws_pkg::WAVE_DEPTH_DEF,
    parameter int ENVELOPE_DEPTH = fvws_pkg::ENVELOPE_DEPTH_DEF,
    parameter int PITCH_DEPTH    = fvws_pkg::PITCH_DEPTH_DEF,
    parameter int SONG_DEPTH     = fvws_pkg::SONG_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire  [12:0]          i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  fvws_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output fvws_pkg::t_out_item  o_out_item
);
    import fvws_pkg::*;

    logic        in_xfer;
    logic        tick;
    logic        wave_we, env_we, pitch_we, song_we;
    logic        seq_busy;
    logic        mix_free;
    t_voice_load load;
    logic [7:0]  wave [VOICES];
    logic [7:0]  env  [VOICES];

    // Accept when the sequencer is idle and the fetch stage can take a tick
    assign o_in_ready = !seq_busy && mix_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Command decode
    always_comb begin
        tick     = 1'b0;
        wave_we  = 1'b0;
        env_we   = 1'b0;
        pitch_we = 1'b0;
        song_we  = 1'b0;
        if (in_xfer) begin
            case (i_in_item.command)
                CMD_TICK:  tick     = 1'b1;
                CMD_WAVE:  wave_we  = 1'b1;
                CMD_ENV:   env_we   = 1'b1;
                CMD_PITCH: pitch_we = 1'b1;
                CMD_SONG:  song_we  = 1'b1;
                default: ;
            endcase
        end
    end

    fvws_sequencer #(
        .VOICES      (VOICES),
        .PITCH_DEPTH (PITCH_DEPTH),
        .SONG_DEPTH  (SONG_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (tick),
        .i_pitch_we  (pitch_we),
        .i_song_we   (song_we),
        .i_addr      (i_in_item.address),
        .i_data      (i_in_item.value),
        .o_busy      (seq_busy),
        .o_load      (load)
    );

    fvws_voices #(
        .VOICES         (VOICES),
        .WAVE_DEPTH     (WAVE_DEPTH),
        .ENVELOPE_DEPTH (ENVELOPE_DEPTH)
    ) u_voices (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_wave_we (wave_we),
        .i_env_we  (env_we),
        .i_addr    (i_in_item.address),
        .i_data    (i_in_item.value[7:0]),
        .i_load    (load),
        .o_wave    (wave),
        .o_env     (env)
    );

    fvws_mixer #(
        .VOICES (VOICES)
    ) u_mixer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_wave      (wave),
        .i_env       (env),
        .o_free      (mix_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // A retrigger never lands on a cycle where a tick is taken
    a_load_no_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load.en |-> !tick)
        else $error("voice retrigger collides with a tick transfer");

    // A retrigger only follows a sequencer fetch
    a_load_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load.en |-> $past(seq_busy))
        else $error("voice retrigger without a preceding song fetch");

    // A tick taken while the output is idle yields a sample through the fetch stage and the output register
    a_tick_to_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick && !o_out_valid) |-> ##2 o_out_valid)
        else $error("tick transfer produced no sample");

endmodule
`default_nettype wire

### verif/fvws_checker.sv
// Checker: tracks the synthesizer state, predicts each sample and compares transfers.
`timescale 1ns / 1ps
module fvws_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire  [12:0]          i_cfg_data,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  fvws_pkg::t_in_item   i_in_item,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  fvws_pkg::t_out_item  i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import fvws_pkg::*;

    localparam int NV = VOICES_DEF;

    // Predicted machine state
    logic [7:0]  divide_by;
    logic [12:0] pause_len;
    logic [15:0] phase_acc [NV];
    logic [15:0] phase_step [NV];
    logic [15:0] env_pos [NV];
    logic [7:0]  wave_mem [WAVE_DEPTH_DEF];
    logic [7:0]  env_mem [ENVELOPE_DEPTH_DEF];
    logic [15:0] pitch_mem [PITCH_DEPTH_DEF];
    logic [23:0] song_mem [SONG_DEPTH_DEF];
    int unsigned tick_count;
    logic [12:0] steps_left;
    int unsigned song_pos;

    t_out_item sample_q [$];
    int        fails;

    // Read the next song entry once the delay runs out
    function automatic void advance_song();
        logic [23:0] entry;
        logic [7:0]  note;
        logic [15:0] word;
        int          idx;
        int          v;
        if (steps_left > 0) steps_left--;
        if (steps_left != 0) return;
        entry    = song_mem[song_pos % SONG_DEPTH_DEF];
        song_pos = (song_pos + 1) % SONG_DEPTH_DEF;
        note       = entry[7:0];
        word       = entry[23:8];
        v          = int'(word[1:0]) % NV;
        steps_left = word[15:3];
        if (note != 0) begin
            idx = int'(note) - int'(NOTE_OFFSET);
            if (idx < 0) idx = 0;
            if (idx > PITCH_DEPTH_DEF - 1) idx = PITCH_DEPTH_DEF - 1;
            phase_step[v] = pitch_mem[idx];
            env_pos[v]    = '0;
            phase_acc[v]  = '0;
        end else if (steps_left == 0) begin
            steps_left = pause_len;
            song_pos   = 1 % SONG_DEPTH_DEF;
        end
    endfunction

    // Mix one sample and clock the sequencer divider
    function automatic t_out_item mix_sample();
        t_out_item   s;
        int unsigned sum_l, sum_r, wave, env, part;
        logic [7:0]  l8, r8;
        sum_l = 0;
        sum_r = 0;
        for (int v = 0; v < NV; v++) begin
            phase_acc[v] = phase_acc[v] + phase_step[v];
            wave = wave_mem[(phase_acc[v] >> 10) % WAVE_DEPTH_DEF];
            env  = 0;
            if ((env_pos[v] >> 8) < ENVELOPE_DEPTH_DEF) begin
                env = env_mem[env_pos[v] >> 8];
                env_pos[v]++;
            end
            part = (wave * env) >> 8;
            if (v < NV / 2) sum_l += part;
            else sum_r += part;
        end
        l8 = 8'(sum_l >> 1);
        r8 = 8'(sum_r >> 1);
        s.left_sample  = {l8 ^ 8'h80, 8'h00};
        s.right_sample = {r8 ^ 8'h80, 8'h00};
        tick_count++;
        if (tick_count >= divide_by) begin
            tick_count = 0;
            advance_song();
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            divide_by  = DIVIDER_RESET;
            pause_len  = END_PAUSE_RESET;
            for (int v = 0; v < NV; v++) begin
                phase_acc[v]  = '0;
                phase_step[v] = '0;
                env_pos[v]    = '0;
            end
            tick_count = 0;
            steps_left = 13'd1;
            song_pos   = 0;
            sample_q.delete();
            fails      = 0;
        end else begin
            // Compare a sample transfer with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected sample: left %0d right %0d",
                           i_out_item.left_sample, i_out_item.right_sample);
                    fails++;
                end else begin
                    want = sample_q.pop_front();
                    if (i_out_item.left_sample !== want.left_sample) begin
                        $error("left_sample: expected %0d, got %0d",
                               want.left_sample, i_out_item.left_sample);
                        fails++;
                    end
                    if (i_out_item.right_sample !== want.right_sample) begin
                        $error("right_sample: expected %0d, got %0d",
                               want.right_sample, i_out_item.right_sample);
                        fails++;
                    end
                end
            end
            // Apply register writes
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TICK_DIVIDER) divide_by = i_cfg_data[7:0];
                else pause_len = i_cfg_data;
            end
            // Apply command transfers
            if (i_in_valid && i_in_ready) begin
                case (t_cmd'(i_in_item.command))
                    CMD_TICK: begin
                        sample_q.push_back(mix_sample());
                    end
                    CMD_WAVE: begin
                        wave_mem[i_in_item.address % WAVE_DEPTH_DEF] = i_in_item.value[7:0];
                    end
                    CMD_ENV: begin
                        env_mem[i_in_item.address % ENVELOPE_DEPTH_DEF] = i_in_item.value[7:0];
                    end
                    CMD_PITCH: begin
                        pitch_mem[i_in_item.address % PITCH_DEPTH_DEF] = i_in_item.value[15:0];
                    end
                    CMD_SONG: begin
                        song_mem[i_in_item.address % SONG_DEPTH_DEF] = i_in_item.value;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= sample_q.size();
    end

endmodule

### verif/testbench.sv
// Testbench top: drives commands, registers and output stalls, and reports the verdict.
`timescale 1ns / 1ps
module testbench;
    import fvws_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;
    int          song_end_pos;

    four_voice_wavetable_sequencer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    fvws_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Stall the sample channel at random
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command and hold it until transferred
    task automatic push(input logic [2:0] cmd, input logic [9:0] addr, input logic [23:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid        <= 1'b1;
        in_item.command <= cmd;
        in_item.address <= addr;
        in_item.value   <= val;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every sample has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic idx, input logic [12:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Song word: note in 7:0, voice in 9:8, delay in 23:11
    function automatic logic [23:0] song_entry(input int pos, input bit voice0_only);
        logic [7:0]  note;
        logic [12:0] delay;
        logic [2:0]  low;
        low   = 3'($urandom_range(7));
        if (voice0_only) low[1:0] = 2'b00;
        if (pos == song_end_pos) return {13'd0, low, 8'd0};
        note  = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(1, 255));
        delay = ($urandom_range(99) < 3) ? 13'($urandom_range(1, 8191))
                                         : 13'($urandom_range(1, 3));
        return {delay, low, note};
    endfunction

    task automatic load_song(input bit voice0_only);
        for (int a = 0; a < SONG_DEPTH_DEF; a++)
            push(CMD_SONG, 10'(a), song_entry(a, voice0_only));
    endtask

    task automatic random_items(input int count);
        int          roll;
        logic [2:0]  cmd;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 75) cmd = CMD_TICK;
            else if (roll < 95) cmd = 3'($urandom_range(CMD_WAVE, CMD_SONG));
            else cmd = 3'(CMD_SONG) + 3'($urandom_range(1, 3));
            push(cmd, 10'($urandom), 24'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_TICK_DIVIDER;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_ready     = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 60;
        song_end_pos  = $urandom_range(10, 40);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every table entry before the first tick
        for (int a = 0; a < WAVE_DEPTH_DEF; a++) push(CMD_WAVE, 10'(a), 24'($urandom));
        for (int a = 0; a < ENVELOPE_DEPTH_DEF; a++) push(CMD_ENV, 10'(a), 24'($urandom));
        for (int a = 0; a < PITCH_DEPTH_DEF; a++) push(CMD_PITCH, 10'(a), 24'($urandom));
        load_song(1'b0);

        // Directed: extreme registers, divider lowered below the count, zero settings
        set_reg(REG_TICK_DIVIDER, 13'd255);
        set_reg(REG_END_PAUSE, 13'd8191);
        repeat (5) push(CMD_TICK, 10'h3FF, 24'hFFFFFF);
        set_reg(REG_TICK_DIVIDER, 13'd1);
        repeat (5) push(CMD_TICK, 10'h000, 24'h000000);
        set_reg(REG_TICK_DIVIDER, 13'd0);
        set_reg(REG_END_PAUSE, 13'd0);
        repeat (8) push(CMD_TICK, 10'h155, 24'hAAAAAA);
        push(CMD_WAVE, 10'h3FF, 24'hFFFFFF);
        push(CMD_ENV, 10'h3FF, 24'h0000FF);
        push(CMD_PITCH, 10'h3FF, 24'h00FFFF);
        for (int c = 1; c <= 3; c++) push(3'(CMD_SONG) + 3'(c), 10'h2AA, 24'h555555);
        push(CMD_TICK, 10'h000, 24'h000000);

        // Random phases with different idling and register settings
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 34 : (p == 1) ? 60 : 0;
            recv_idle_pct = (p == 0) ? 60 : (p == 1) ? 34 : 0;
            set_reg(REG_TICK_DIVIDER, 13'($urandom_range(1, 4)));
            set_reg(REG_END_PAUSE, (p == 1) ? 13'($urandom_range(1, 8191))
                                           : 13'($urandom_range(1, 20)));
            random_items(150);
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
